FILE: sv/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// Shared types and constants for the 8-bit RGB to HSV converter: pixel and
// result beats, the side band carried down the divider chain, and the lane
// state of one restoring-division cell.
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int RTH_W     = 8;
    // One cell resolves one quotient bit of both divisions.
    localparam int RTH_CELLS = RTH_W;
    // Start sample to result strobe sample: front stage, cells, output register.
    localparam int RTH_LAT   = RTH_CELLS + 2;

    localparam logic [RTH_W-1:0] HSV_FULL      = 8'd255;
    localparam logic [RTH_W-1:0] HSV_SEXTANT   = 8'd43;
    localparam logic [RTH_W-1:0] HSV_OFS_RED   = 8'd0;
    localparam logic [RTH_W-1:0] HSV_OFS_GREEN = 8'd85;
    localparam logic [RTH_W-1:0] HSV_OFS_BLUE  = 8'd171;

    typedef struct packed {
        logic [RTH_W-1:0] red;
        logic [RTH_W-1:0] green;
        logic [RTH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [RTH_W-1:0] hue;
        logic [RTH_W-1:0] saturation;
        logic [RTH_W-1:0] brightness;
    } t_hsv;

    // Partial remainder, numerator bits still to bring down (quotient bits
    // shift in from the bottom), divisor.
    typedef struct packed {
        logic [RTH_W-1:0] rem;
        logic [RTH_W-1:0] nq;
        logic [RTH_W-1:0] den;
    } t_lane;

    typedef struct packed {
        logic             black;
        logic             neg;
        logic [RTH_W-1:0] offset;
        logic [RTH_W-1:0] hi;
    } t_side;

    typedef struct packed {
        t_side side;
        t_lane sat;
        t_lane hue;
    } t_stage;

endpackage

FILE: sv/rth_prep.sv
// ----------------------------------------------------------------------------
// rth_prep
// Front stage: find max and min, pick the sextant, form both dividends and
// load the first lane state of the divider chain.
// ----------------------------------------------------------------------------
module rth_prep import rth_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_pixel i_pixel,
    output logic   o_valid,
    output t_stage o_stage
);

    logic [RTH_W-1:0]   hi, lo, span, a, b, mag, offset;
    logic               neg;
    logic [2*RTH_W-1:0] sat_num, hue_num;
    t_stage             n_stage;
    logic               r_valid;
    t_stage             r_stage;

    always_comb begin
        hi = (i_pixel.red > i_pixel.green)
           ? ((i_pixel.red > i_pixel.blue) ? i_pixel.red : i_pixel.blue)
           : ((i_pixel.green > i_pixel.blue) ? i_pixel.green : i_pixel.blue);
        lo = (i_pixel.red < i_pixel.green)
           ? ((i_pixel.red < i_pixel.blue) ? i_pixel.red : i_pixel.blue)
           : ((i_pixel.green < i_pixel.blue) ? i_pixel.green : i_pixel.blue);
        span = hi - lo;

        // red wins ties, then green
        if (hi == i_pixel.red) begin
            offset = HSV_OFS_RED;
            a      = i_pixel.green;
            b      = i_pixel.blue;
        end else if (hi == i_pixel.green) begin
            offset = HSV_OFS_GREEN;
            a      = i_pixel.blue;
            b      = i_pixel.red;
        end else begin
            offset = HSV_OFS_BLUE;
            a      = i_pixel.red;
            b      = i_pixel.green;
        end
        neg = (a < b);
        mag = neg ? (b - a) : (a - b);

        sat_num = (2*RTH_W)'(HSV_FULL) * (2*RTH_W)'(span);
        hue_num = (2*RTH_W)'(HSV_SEXTANT) * (2*RTH_W)'(mag);

        n_stage.side.black  = (hi == '0);
        n_stage.side.neg    = neg;
        n_stage.side.offset = offset;
        n_stage.side.hi     = hi;
        n_stage.sat.rem     = sat_num[2*RTH_W-1:RTH_W];
        n_stage.sat.nq      = sat_num[RTH_W-1:0];
        n_stage.sat.den     = hi;
        n_stage.hue.rem     = hue_num[2*RTH_W-1:RTH_W];
        n_stage.hue.nq      = hue_num[RTH_W-1:0];
        n_stage.hue.den     = span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: sv/rth_cell.sv
// ----------------------------------------------------------------------------
// rth_cell
// One restoring-division cell: bring down a numerator bit, trial-subtract the
// divisor, shift the quotient bit in. Both lanes step together.
// ----------------------------------------------------------------------------
module rth_cell import rth_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_valid,
    output t_stage o_stage
);

    function automatic t_lane step(input t_lane l);
        logic [RTH_W:0]   t;
        logic             q;
        t_lane            r;
        t = {l.rem, l.nq[RTH_W-1]};
        q = (t >= {1'b0, l.den});
        r.rem = q ? RTH_W'(t - {1'b0, l.den}) : t[RTH_W-1:0];
        r.nq  = {l.nq[RTH_W-2:0], q};
        r.den = l.den;
        return r;
    endfunction

    logic   r_valid;
    t_stage r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage.side <= i_stage.side;
        r_stage.sat  <= step(i_stage.sat);
        r_stage.hue  <= step(i_stage.hue);
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: sv/rth_post.sv
// ----------------------------------------------------------------------------
// rth_post
// Output stage: apply the sign and sextant offset to the hue quotient, force
// black and grey pixels, register the result beat.
// ----------------------------------------------------------------------------
module rth_post import rth_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_valid,
    output t_hsv   o_hsv
);

    logic [RTH_W-1:0] sat_q, hue_q, part;
    t_hsv             n_hsv;
    logic             r_valid;
    t_hsv             r_hsv;

    always_comb begin
        sat_q = i_stage.sat.nq;
        hue_q = i_stage.hue.nq;
        part  = i_stage.side.neg ? RTH_W'(0 - hue_q) : hue_q;
        if (i_stage.side.black) begin
            n_hsv = '0;
        end else begin
            n_hsv.brightness = i_stage.side.hi;
            n_hsv.saturation = sat_q;
            n_hsv.hue        = (sat_q == '0) ? '0 : RTH_W'(i_stage.side.offset + part);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hsv <= n_hsv;
    end

    assign o_valid = r_valid;
    assign o_hsv   = r_hsv;

endmodule

FILE: sv/rgb_to_hsv_8bit_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit_top
// 8-bit RGB to HSV converter built as a chain of restoring-division cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_pixel and raise start; a beat is taken at every rising edge with
//   start high and busy low. busy is never raised, so a pixel may be offered
//   on every cycle.
//   Each pixel leaves as one result beat on o_hsv, marked by o_valid for a
//   single cycle. The receiver cannot stall: take the beat in that cycle.
//   Path from a taken pixel to its result: one front stage (max/min,
//   sextant, two small multiplies), eight division cells (one quotient
//   bit each, saturation and hue lanes side by side), one output stage
//   (sign, offset, black and grey forcing).
//   Throughput: one pixel per cycle, set by the fully pipelined cell chain.
//   Results leave in the order the pixels arrived.
//   Reset (synchronous, active low) clears every valid flag in the chain;
//   pixels in flight are dropped, payload registers keep stale data.
// ----------------------------------------------------------------------------
module rgb_to_hsv_8bit_top import rth_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  t_pixel i_pixel,
    output logic   o_valid,
    output t_hsv   o_hsv
);

    // Stage k feeds cell k; stage 0 comes from the front stage.
    logic   stage_valid [RTH_CELLS+1];
    t_stage stage       [RTH_CELLS+1];

    // The chain never holds off a pixel.
    assign busy = 1'b0;

    // Form dividends and side band
    rth_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_pixel (i_pixel),
        .o_valid (stage_valid[0]),
        .o_stage (stage[0])
    );

    // Advance both divisions one quotient bit per cell, MSB first
    for (genvar k = 0; k < RTH_CELLS; k++) begin : g_cell
        rth_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_valid[k]),
            .i_stage (stage[k]),
            .o_valid (stage_valid[k+1]),
            .o_stage (stage[k+1])
        );
    end

    // Assemble and register the result beat
    rth_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid[RTH_CELLS]),
        .i_stage (stage[RTH_CELLS]),
        .o_valid (o_valid),
        .o_hsv   (o_hsv)
    );

    // Every taken pixel yields a beat after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##RTH_LAT o_valid)
        else $error("result beat missing after fixed latency");

    // No beat without a pixel taken the fixed latency earlier
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, RTH_LAT))
        else $error("result beat without a matching pixel");

    // Black pixels give an all-zero beat
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_hsv.brightness == '0) |->
            (o_hsv.saturation == '0) && (o_hsv.hue == '0))
        else $error("black pixel with non-zero hue or saturation");

    // Grey pixels carry zero hue
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_hsv.saturation == '0) |-> (o_hsv.hue == '0))
        else $error("zero saturation with non-zero hue");

endmodule

FILE: verif/rgb_to_hsv_8bit_top_test.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit_top_test
// Self-checking bench for the 8-bit RGB to HSV converter. Directed pixels
// cover black, grey, the primaries, tied maxima and a hue that wraps below
// zero. A random pixel stream follows, biased towards greys, ties and narrow
// spans, under three sender idling profiles. Every result beat is checked,
// field by field, against an independent integer model of the conversion.
// ----------------------------------------------------------------------------
module rgb_to_hsv_8bit_top_test import rth_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    // Conversion constants, kept apart from the package so that a wrong
    // constant in the design cannot hide behind the same wrong value here.
    localparam int SAT_SCALE   = 255;
    localparam int HUE_STEP    = 43;
    localparam int HUE_AT_RED  = 0;
    localparam int HUE_AT_GRN  = 85;
    localparam int HUE_AT_BLU  = 171;

    // Cycles with no beat in either direction before the run is abandoned.
    // The pipeline never holds off a pixel and sender gaps are short, so
    // this is far beyond anything a correct run produces.
    localparam int STALL_LIMIT = 2000;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start   = 1'b0;
    logic   busy;
    t_pixel i_pixel = '0;
    logic   o_valid;
    t_hsv   o_hsv;

    // Results still owed by the converter, oldest first.
    t_hsv   hsv_due[$];
    int     fail_count = 0;
    int     quiet_cycles = 0;
    // Percentage of cycles in which the sender holds back before a pixel.
    int     idle_pct = 0;

    rgb_to_hsv_8bit_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .o_hsv   (o_hsv)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Expected HSV of one pixel. Value is the largest channel; saturation is
    // 255*(max-min)/max truncated; hue is the sextant offset plus a signed
    // 43*diff/span quotient truncated towards zero, wrapped to eight bits.
    // ------------------------------------------------------------------------
    function automatic t_hsv hsv_of(input t_pixel px);
        int   r, g, b;
        int   hi, lo, span, sat;
        int   lead, trail, offset, quot;
        t_hsv res;
        r   = int'(px.red);
        g   = int'(px.green);
        b   = int'(px.blue);
        res = '0;
        hi  = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        lo  = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        // Black pixel: everything stays zero.
        if (hi == 0)
            return res;
        span           = hi - lo;
        sat            = (SAT_SCALE * span) / hi;
        res.brightness = 8'(hi);
        res.saturation = 8'(sat);
        // Grey pixel: no saturation, hue pinned at zero.
        if (sat == 0)
            return res;
        // Red is tested first, then green, so a tied maximum takes the
        // earlier channel's sextant.
        if (hi == r) begin
            lead   = g;
            trail  = b;
            offset = HUE_AT_RED;
        end else if (hi == g) begin
            lead   = b;
            trail  = r;
            offset = HUE_AT_GRN;
        end else begin
            lead   = r;
            trail  = g;
            offset = HUE_AT_BLU;
        end
        // Divide the magnitude so the quotient truncates towards zero, then
        // reapply the sign; the eight-bit cast does the modulo-256 wrap.
        if (lead >= trail) begin
            quot = (HUE_STEP * (lead - trail)) / span;
            res.hue = 8'(offset + quot);
        end else begin
            quot = (HUE_STEP * (trail - lead)) / span;
            res.hue = 8'(offset - quot);
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $realtime, name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Beat monitor. Sample both handshakes on the same edge the design does:
    // check an outgoing result against the oldest expectation first, then
    // queue the prediction for a pixel taken on this edge. Both live in one
    // block so the queue never depends on process ordering within a step.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic beat_seen;
        t_hsv want;
        beat_seen = 1'b0;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                beat_seen = 1'b1;
                if (hsv_due.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding, actual %p",
                             $realtime, o_hsv);
                    fail_count++;
                end else begin
                    want = hsv_due.pop_front();
                    check_field("hue",        want.hue,        o_hsv.hue);
                    check_field("saturation", want.saturation, o_hsv.saturation);
                    check_field("brightness", want.brightness, o_hsv.brightness);
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                beat_seen = 1'b1;
                hsv_due.push_back(hsv_of(i_pixel));
            end
        end
        // Watchdog: count edges where nothing moved in either direction.
        if (beat_seen)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $realtime, STALL_LIMIT, hsv_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Offer one pixel. Hold off at random first, then raise start and hold
    // it with the pixel until an edge takes the beat. start is left high on
    // return so back-to-back pixels need no extra drive in the same step.
    // ------------------------------------------------------------------------
    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pixel <= '{red: r, green: g, blue: b};
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
    endtask

    // Black, the smallest non-black grey, a mid grey, full white and a dim blue.
    task automatic test_black_and_grey();
        send_rgb(8'd0,   8'd0,   8'd0);
        send_rgb(8'd1,   8'd1,   8'd1);
        send_rgb(8'd128, 8'd128, 8'd128);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd0,   8'd0,   8'd1);
    endtask

    // Pure and mixed primaries, including the narrowest non-grey spans.
    task automatic test_primaries();
        send_rgb(8'd255, 8'd0,   8'd0);
        send_rgb(8'd0,   8'd255, 8'd0);
        send_rgb(8'd0,   8'd0,   8'd255);
        send_rgb(8'd255, 8'd128, 8'd0);
        send_rgb(8'd1,   8'd0,   8'd0);
        send_rgb(8'd254, 8'd255, 8'd254);
    endtask

    // Two channels sharing the maximum: the earlier one must win.
    task automatic test_tied_max();
        send_rgb(8'd255, 8'd255, 8'd0);
        send_rgb(8'd0,   8'd255, 8'd255);
        send_rgb(8'd255, 8'd0,   8'd255);
        send_rgb(8'd90,  8'd90,  8'd30);
        send_rgb(8'd30,  8'd90,  8'd90);
        send_rgb(8'd90,  8'd30,  8'd90);
    endtask

    // Red sextant with blue above green: the hue goes negative and wraps.
    task automatic test_negative_hue();
        send_rgb(8'd255, 8'd0,   8'd1);
        send_rgb(8'd200, 8'd10,  8'd100);
        send_rgb(8'd100, 8'd0,   8'd99);
        send_rgb(8'd255, 8'd254, 8'd255);
    endtask

    // ------------------------------------------------------------------------
    // Random pixels. Most are uniform over all 24 bits; the rest steer into
    // greys, tied maxima, narrow spans and saturated channels, where the
    // tie-break and truncation corners sit.
    // ------------------------------------------------------------------------
    task automatic test_random_stream(input int count, input int idle);
        logic [7:0] r, g, b, base;
        int         shape;
        idle_pct = idle;
        for (int n = 0; n < count; n++) begin
            r     = 8'($urandom_range(255));
            g     = 8'($urandom_range(255));
            b     = 8'($urandom_range(255));
            shape = $urandom_range(9);
            case (shape)
                6: begin
                    g = r;
                    b = r;
                end
                7: begin
                    // Tie the top two: copy the largest into another channel.
                    base = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
                    case ($urandom_range(2))
                        0: begin r = base; g = base; end
                        1: begin g = base; b = base; end
                        default: begin r = base; b = base; end
                    endcase
                end
                8: begin
                    // Narrow span around a random level.
                    base = 8'($urandom_range(253, 2));
                    r = base + 8'($urandom_range(2)) - 8'd1;
                    g = base + 8'($urandom_range(2)) - 8'd1;
                    b = base + 8'($urandom_range(2)) - 8'd1;
                end
                9: begin
                    r = $urandom_range(1) ? 8'd255 : 8'd0;
                    if ($urandom_range(1))
                        b = $urandom_range(1) ? 8'd255 : 8'd0;
                end
                default: ;
            endcase
            send_rgb(r, g, b);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset, directed corners, then random traffic under three
    // idling profiles, then drain and report.
    // ------------------------------------------------------------------------
    initial begin
        // Hold reset with start low, then release.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 21;
        test_black_and_grey();
        test_primaries();
        test_tied_max();
        test_negative_hue();

        // Sender idles lightly, then heavily, then streams back to back.
        test_random_stream(250, 21);
        test_random_stream(250, 45);
        test_random_stream(250, 0);

        // Drop start once the last pixel has been taken.
        start <= 1'b0;

        // Drain: wait for every owed result, then let the pipeline run out
        // so a stray extra beat is still caught.
        while (hsv_due.size() != 0)
            @(posedge i_clk);
        repeat (RTH_LAT + 4) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
